FILE: rtl/core/sbda_pkg.sv
// shared types and constants for the signed binary to decimal ascii converter
// no dependencies
`timescale 1ns / 1ps

package sbda_pkg;

   // width of the number port and of one text character
   localparam int NUMBER_W = 64;
   localparam int CHAR_W   = 8;

   // width of the value that is converted (8..64)
   localparam int VALUE_BITS = 64;

   // bcd digits that hold any magnitude up to 2^(VALUE_BITS-1)
   localparam int BCD_DIGITS = (VALUE_BITS * 3) / 10 + 1;
   localparam int BCD_W      = BCD_DIGITS * 4;

   // counter widths
   localparam int CNT_W  = $clog2(VALUE_BITS);
   localparam int DCNT_W = $clog2(BCD_DIGITS + 1);

   // ascii codes
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_SIGN,
      ST_SKIP,
      ST_DIGIT
   } state_type;

endpackage

FILE: rtl/core/signed_binary_to_decimal_ascii.sv
// signed binary to decimal ascii converter, bit-serial double dabble core
// depends on sbda_pkg
//
//   channel  direction  ports                               content
//   req      in         req_valid req_stall req_number      one signed value
//   rsp      out        rsp_valid rsp_stall rsp_text_char   one ascii character
//                       rsp_last_char                       last flag on final char
//
// a word is loaded, then shifted through the double dabble loop one magnitude bit per
// cycle; a negative word then sends the minus sign, and each bcd digit position is then
// skipped or sent, the skip state handing over to the digit state at the first sent digit.
// one word is in flight at a time; req_stall is high from load until the last char
// is taken. reset is synchronous and returns the control to idle.
// rsp_stall holds the current character in place.
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [sbda_pkg::NUMBER_W-1:0] req_number,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [sbda_pkg::CHAR_W-1:0]         rsp_text_char,
   output logic                                rsp_last_char
);
   import sbda_pkg::*;

   localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(VALUE_BITS - 1);
   localparam logic [DCNT_W-1:0] DCNT_ONE = DCNT_W'(1);
   localparam logic [DCNT_W-1:0] DCNT_ALL = DCNT_W'(BCD_DIGITS);

   state_type               state_ff, state_in;
   logic [VALUE_BITS-1:0]   mag_ff, mag_in;
   logic                    neg_ff, neg_in;
   logic [BCD_W-1:0]        bcd_ff, bcd_in;
   logic [CNT_W-1:0]        bit_cnt_ff, bit_cnt_in;
   logic [DCNT_W-1:0]       dig_cnt_ff, dig_cnt_in;

   logic [VALUE_BITS-1:0]   raw;
   logic                    raw_neg;
   logic [VALUE_BITS-1:0]   raw_mag;
   logic [BCD_W-1:0]        bcd_adj;
   logic [3:0]              top_digit;
   logic                    skip_zero;

   // magnitude of the incoming word, most negative value included
   assign raw     = req_number[VALUE_BITS-1:0];
   assign raw_neg = raw[VALUE_BITS-1];
   assign raw_mag = raw_neg ? (~raw) + VALUE_BITS'(1) : raw;

   // add 3 to every bcd digit of 5 or more before the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            bcd_adj[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign skip_zero = (top_digit == 4'd0) && (dig_cnt_ff != DCNT_ONE);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (bit_cnt_ff == '0) state_in = neg_ff ? ST_SIGN : ST_SKIP;
         end
         ST_SIGN: begin
            if (!rsp_stall) state_in = ST_SKIP;
         end
         ST_SKIP: begin
            if (!skip_zero) state_in = ST_DIGIT;
         end
         ST_DIGIT: begin
            if (!rsp_stall && dig_cnt_ff == DCNT_ONE) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // handshake and character outputs
   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      rsp_valid     = (state_ff == ST_SIGN) || (state_ff == ST_DIGIT);
      rsp_text_char = ASCII_ZERO | {4'd0, top_digit};
      rsp_last_char = 1'b0;
      case (state_ff)
         ST_SIGN: begin
            rsp_text_char = ASCII_MINUS;
         end
         ST_DIGIT: begin
            rsp_last_char = (dig_cnt_ff == DCNT_ONE);
         end
         default: begin
            rsp_last_char = 1'b0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      mag_in     = mag_ff;
      neg_in     = neg_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mag_in     = raw_mag;
               neg_in     = raw_neg;
               bcd_in     = '0;
               bit_cnt_in = CNT_MAX;
               dig_cnt_in = DCNT_ALL;
            end
         end
         ST_CONVERT: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_BITS-1]};
            mag_in     = {mag_ff[VALUE_BITS-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff - CNT_W'(1);
         end
         ST_SKIP: begin
            if (skip_zero) begin
               bcd_in     = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - DCNT_ONE;
            end
         end
         ST_DIGIT: begin
            if (!rsp_stall) begin
               bcd_in     = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_cnt_in = dig_cnt_ff - DCNT_ONE;
            end
         end
         default: begin
            bcd_in = bcd_ff;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      neg_ff     <= neg_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
   end

   // an accepted word always starts the shift loop
   a_accept_converts: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_CONVERT)
      else $error("accepted word did not start conversion");

   // a minus sign is only sent for a negative word
   a_sign_negative: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SIGN |-> neg_ff)
      else $error("minus sign for a non-negative word");

   // the digit counter never runs out while digits are sent
   a_digit_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIGIT |-> dig_cnt_ff != '0)
      else $error("digit counter underflow");

   // no new word is taken while characters are still going out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while output busy");

endmodule
